### rtl/hsv_to_rgb_converter_defines.svh
// Assertion macros used by the port-level checker of the HSV to RGB converter.
// Depends on nothing; every macro expects clk_i and rst_ni in the using scope.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset.
`define HSVRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication with a fixed delay between cause and effect.
`define HSVRGB_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##dly (cons)) else $error(msg);

`endif

### rtl/hsvrgb_pkg.sv
// Shared types, constants and helper functions of the HSV to RGB converter.
// Depends on nothing; imported by every module of the block.
package hsvrgb_pkg;

  // Field widths and fixed-point scaling.
  localparam int HueBits  = 16;
  localparam int ChanBits = 8;
  localparam int NumBits  = 24;                       // holds 255 * 2^HueBits
  localparam int ZBits    = 16;                       // holds 255 * 255
  localparam logic [HueBits:0]   HueDen   = 17'h1_0000;
  localparam logic [NumBits-1:0] LevelFull = 24'hFF_0000;
  localparam logic [ChanBits-1:0] ChanMax = 8'hFF;

  // Hue sector, one sixth of the circle each.
  typedef enum logic [2:0] {
    SectorRedYel = 3'd0,
    SectorYelGrn = 3'd1,
    SectorGrnCyn = 3'd2,
    SectorCynBlu = 3'd3,
    SectorBluMag = 3'd4,
    SectorMagRed = 3'd5
  } sector_e;

  // Input and output payloads.
  typedef struct packed {
    logic [HueBits-1:0]  hue;
    logic [ChanBits-1:0] saturation;
    logic [ChanBits-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
  } rgb_t;

  // Stage 1: sector and fractional position.
  typedef struct packed {
    sector_e             sector;
    logic [HueBits-1:0]  frac;
    logic [HueBits:0]    frac_inv;
    logic [ChanBits-1:0] sat;
    logic [ChanBits-1:0] val;
  } st1_t;

  // Stage 2: numerators of the falling and rising levels, scaled low level.
  typedef struct packed {
    sector_e             sector;
    logic [NumBits-1:0]  num_q;
    logic [NumBits-1:0]  num_t;
    logic [ZBits-1:0]    z_p;
    logic [ChanBits-1:0] val;
  } st2_t;

  // Stage 3: all three levels scaled by 255, ready for the final divide.
  typedef struct packed {
    sector_e             sector;
    logic [ZBits-1:0]    z_p;
    logic [ZBits-1:0]    z_q;
    logic [ZBits-1:0]    z_t;
    logic [ChanBits-1:0] val;
  } st3_t;

  // Exact floor(z / 255) for z up to 255 * 255, by reciprocal and correction.
  function automatic logic [ChanBits-1:0] div255(input logic [ZBits-1:0] z);
    logic [ZBits:0] sum;
    sum = {1'b0, z} + {9'd0, z[ZBits-1:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

### rtl/hsvrgb_sector.sv
// First pipeline stage: splits the hue into sector and fractional position.
// Depends on hsvrgb_pkg.
module hsvrgb_sector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hsvrgb_pkg::hsv_t   pixel_i,
  output logic               valid_o,
  output hsvrgb_pkg::st1_t   stage_o
);
  import hsvrgb_pkg::*;

  logic [HueBits+2:0] hue_x6;
  st1_t               stage_d, stage_q;
  logic               valid_q;

  // Hue times six as a shift-add; the top three bits are the sector.
  always_comb begin
    hue_x6 = ({3'b000, pixel_i.hue} << 2) + ({3'b000, pixel_i.hue} << 1);
    stage_d.sector   = sector_e'(hue_x6[HueBits+2:HueBits]);
    stage_d.frac     = hue_x6[HueBits-1:0];
    stage_d.frac_inv = HueDen - {1'b0, hue_x6[HueBits-1:0]};
    stage_d.sat      = pixel_i.saturation;
    stage_d.val      = pixel_i.brightness;
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload register of the stage.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/hsvrgb_level.sv
// Second and third pipeline stages: products that form the p, q and t levels.
// Depends on hsvrgb_pkg.
module hsvrgb_level (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hsvrgb_pkg::st1_t   stage_i,
  output logic               valid_o,
  output hsvrgb_pkg::st3_t   stage_o
);
  import hsvrgb_pkg::*;

  logic [NumBits-1:0]   fs_q, fs_t;
  logic [2*NumBits-1:0] prod_q, prod_t;
  st2_t                 mid_d, mid_q;
  st3_t                 out_d, out_q;
  logic                 mid_valid_q, out_valid_q;

  // Fraction times saturation, and brightness times (255 - saturation).
  always_comb begin
    fs_q = NumBits'(stage_i.frac) * NumBits'(stage_i.sat);
    fs_t = NumBits'(stage_i.frac_inv) * NumBits'(stage_i.sat);
    mid_d.sector = stage_i.sector;
    mid_d.num_q  = LevelFull - fs_q;
    mid_d.num_t  = LevelFull - fs_t;
    mid_d.z_p    = ZBits'(stage_i.val) * ZBits'(ChanMax - stage_i.sat);
    mid_d.val    = stage_i.val;
  end

  // Brightness times numerator; dropping the low hue bits divides by 2^HueBits.
  always_comb begin
    prod_q = NumBits'(mid_q.val) * mid_q.num_q;
    prod_t = NumBits'(mid_q.val) * mid_q.num_t;
    out_d.sector = mid_q.sector;
    out_d.z_p    = mid_q.z_p;
    out_d.z_q    = prod_q[HueBits+ZBits-1:HueBits];
    out_d.z_t    = prod_t[HueBits+ZBits-1:HueBits];
    out_d.val    = mid_q.val;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= valid_i;
      out_valid_q <= mid_valid_q;
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mid_q <= mid_d;
    end
    if (mid_valid_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign stage_o = out_q;

endmodule

### rtl/hsvrgb_select.sv
// Last pipeline stage: divides the levels by 255 and picks channels by sector.
// Depends on hsvrgb_pkg.
module hsvrgb_select (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hsvrgb_pkg::st3_t   stage_i,
  output logic               valid_o,
  output hsvrgb_pkg::rgb_t   rgb_o
);
  import hsvrgb_pkg::*;

  logic [ChanBits-1:0] lvl_p, lvl_q, lvl_t, lvl_v;
  rgb_t                rgb_d, rgb_q;
  logic                valid_q;

  // Final scaling of the three derived levels.
  always_comb begin
    lvl_p = div255(stage_i.z_p);
    lvl_q = div255(stage_i.z_q);
    lvl_t = div255(stage_i.z_t);
    lvl_v = stage_i.val;
  end

  // Six-way sector mux.
  always_comb begin
    unique case (stage_i.sector)
      SectorRedYel: rgb_d = '{red: lvl_v, green: lvl_t, blue: lvl_p};
      SectorYelGrn: rgb_d = '{red: lvl_q, green: lvl_v, blue: lvl_p};
      SectorGrnCyn: rgb_d = '{red: lvl_p, green: lvl_v, blue: lvl_t};
      SectorCynBlu: rgb_d = '{red: lvl_p, green: lvl_q, blue: lvl_v};
      SectorBluMag: rgb_d = '{red: lvl_t, green: lvl_p, blue: lvl_v};
      default:      rgb_d = '{red: lvl_v, green: lvl_p, blue: lvl_q};
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

### rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: a four-stage pipeline.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_level and hsvrgb_select.
//
//   Channel   Ports                      Transfer when
//   --------  -------------------------  -----------------------------
//   pixel in  start, busy, pixel_i       start high and busy low
//   color out valid_o, rgb_o             valid_o high (one cycle each)
//
// One pixel enters per clock cycle; its color passes through the sector, product,
// scale and select register stages, in that order, before it appears.
// busy stays low: no stage ever holds, so nothing can stall the pipeline.
// Reset clears the valid bits only; data registers keep whatever they hold.
module hsv_to_rgb_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  hsvrgb_pkg::hsv_t   pixel_i,
  output logic               valid_o,
  output hsvrgb_pkg::rgb_t   rgb_o
);
  import hsvrgb_pkg::*;

  logic accept;
  logic s1_valid, s3_valid;
  st1_t s1_stage;
  st3_t s3_stage;

  // The pipeline never holds off a transfer.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Sector and fractional position.
  hsvrgb_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pixel_i (pixel_i),
    .valid_o (s1_valid),
    .stage_o (s1_stage)
  );

  // Level products.
  hsvrgb_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stage_i (s1_stage),
    .valid_o (s3_valid),
    .stage_o (s3_stage)
  );

  // Division by 255 and channel selection.
  hsvrgb_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .stage_i (s3_stage),
    .valid_o (valid_o),
    .rgb_o   (rgb_o)
  );

endmodule

### rtl/hsvrgb_checker.sv
// Port-level checker of the HSV to RGB converter, bound to the top level.
// Depends on hsvrgb_pkg and the assertion macros header.
`include "hsv_to_rgb_converter_defines.svh"

module hsvrgb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input hsvrgb_pkg::hsv_t   pixel_i,
  input logic               valid_o,
  input hsvrgb_pkg::rgb_t   rgb_o
);
  import hsvrgb_pkg::*;

  // Every transfer yields exactly one result, and no result appears without a transfer.
  `HSVRGB_ASSERT_DELAY(a_latency, start && !busy, 4, valid_o, "result missing after transfer")
  `HSVRGB_ASSERT_DELAY(a_no_extra, !(start && !busy), 4, !valid_o, "result without transfer")
  // Black in gives black out.
  `HSVRGB_ASSERT_DELAY(a_black, start && !busy && pixel_i.brightness == '0, 4,
    rgb_o == '0, "zero brightness gave a nonzero color")
  // Zero saturation gives a gray at the input brightness.
  `HSVRGB_ASSERT(a_gray, valid_o && $past(pixel_i.saturation, 4) == '0 |->
    rgb_o.red == $past(pixel_i.brightness, 4) && rgb_o.green == rgb_o.red &&
    rgb_o.blue == rgb_o.red, "zero saturation did not give a gray")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .pixel_i (pixel_i),
  .valid_o (valid_o),
  .rgb_o   (rgb_o)
);
